// ----- rtl/plle_pkg.sv -----
// ---------------------------------------------------------------------------
// plle_pkg
// Shared types and codes for the linked list engine: operation and result
// codes, and the command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package plle_pkg;

  localparam int POS_W = 8;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_LIST      = 3'd6,
    MODE_NOP       = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RA_FREE = 2'd0,
    RA_HEAD = 2'd1,
    RA_LINK = 2'd2
  } rd_addr_sel_t;

  typedef enum logic {
    WA_NODE = 1'b0,
    WA_PREV = 1'b1
  } wr_addr_sel_t;

  typedef enum logic [1:0] {
    WD_HEAD = 2'd0,
    WD_LINK = 2'd1,
    WD_NODE = 2'd2,
    WD_FREE = 2'd3
  } wr_data_sel_t;

  typedef enum logic [1:0] {
    NS_HOLD = 2'd0,
    NS_FREE = 2'd1,
    NS_HEAD = 2'd2,
    NS_LINK = 2'd3
  } node_sel_t;

  typedef enum logic [1:0] {
    HS_HOLD = 2'd0,
    HS_NODE = 2'd1,
    HS_LINK = 2'd2
  } head_sel_t;

  typedef enum logic [1:0] {
    FS_HOLD = 2'd0,
    FS_LINK = 2'd1,
    FS_NODE = 2'd2
  } free_sel_t;

  typedef enum logic [1:0] {
    K_HOLD = 2'd0,
    K_ZERO = 2'd1,
    K_ONE  = 2'd2,
    K_INC  = 2'd3
  } k_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_t;

  typedef enum logic [1:0] {
    OUT_ERR      = 2'd0,
    OUT_OK_ZERO  = 2'd1,
    OUT_OK_VALUE = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic         op_ld;
    logic         rd_en;
    rd_addr_sel_t rd_sel;
    logic         val_wr_en;
    logic         link_wr_en;
    wr_addr_sel_t wa_sel;
    wr_data_sel_t wd_sel;
    node_sel_t    node_sel;
    head_sel_t    head_sel;
    free_sel_t    free_sel;
    logic         prev_ld;
    k_op_t        k_op;
    cnt_op_t      cnt_op;
    logic         out_ld;
    out_sel_t     out_sel;
    logic         out_last;
  } plle_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  pos_zero;
    logic  pos_gt_cnt;
    logic  pos_ge_cnt;
    logic  k_eq_pos;
    logic  list_last;
    logic  out_free;
  } plle_stat_t;

endpackage

// ----- rtl/plle_dp.sv -----
// ---------------------------------------------------------------------------
// plle_dp
// Datapath: node value and link memories, list pointers, element count,
// walk counter and the result register.
// ---------------------------------------------------------------------------
module plle_dp import plle_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  plle_cmd_t               cmd,
  output plle_stat_t              stat,
  input  logic [2:0]              mode,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] data,
  output logic                    last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  mode_t                   op_mode;
  logic [POS_W-1:0]        op_pos;
  logic signed [VAL_W-1:0] op_value;

  logic [IW-1:0] head;
  logic [IW-1:0] free_head;
  logic [IW-1:0] node;
  logic [IW-1:0] cur;
  logic [IW-1:0] prev;
  logic [IW-1:0] count;
  logic [IW-1:0] k;

  logic [IW-1:0]    link_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem  [CAPACITY];
  logic [CAPACITY-1:0] link_vld;

  logic [IW-1:0]    lm_q;
  logic [AW-1:0]    la_q;
  logic             lv_q;
  logic [VAL_W-1:0] val_q;

  logic [IW-1:0]    link_q;
  logic [AW:0]      la_inc;
  logic [IW-1:0]    rd_addr_full;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [IW-1:0]    wr_data;
  logic [POS_W-1:0] target;
  logic [POS_W-1:0] count_ext;
  logic [POS_W-1:0] k_ext;
  logic [IW:0]      k_plus;
  status_t          err_code;

  // link of the last node read; a never written link is the reset chain
  assign la_inc = {1'b0, la_q} + (AW+1)'(1);
  assign link_q = lv_q ? lm_q : la_inc[IW-1:0];

  always_comb begin
    case (cmd.rd_sel)
      RA_FREE: rd_addr_full = free_head;
      RA_HEAD: rd_addr_full = head;
      RA_LINK: rd_addr_full = link_q;
      default: rd_addr_full = head;
    endcase
  end
  assign rd_addr = rd_addr_full[AW-1:0];

  assign wr_addr = (cmd.wa_sel == WA_PREV) ? prev[AW-1:0] : node[AW-1:0];

  always_comb begin
    case (cmd.wd_sel)
      WD_HEAD: wr_data = head;
      WD_LINK: wr_data = link_q;
      WD_NODE: wr_data = node;
      WD_FREE: wr_data = free_head;
      default: wr_data = head;
    endcase
  end

  // node storage
  always_ff @(posedge clk) begin
    if (cmd.link_wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      lm_q <= link_mem[rd_addr];
      lv_q <= link_vld[rd_addr];
      la_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_wr_en) begin
      val_mem[free_head[AW-1:0]] <= op_value;
    end
    if (cmd.rd_en) begin
      val_q <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (cmd.link_wr_en) begin
      link_vld[wr_addr] <= 1'b1;
    end
  end

  // latched operation
  always_ff @(posedge clk) begin
    if (cmd.op_ld) begin
      op_mode  <= mode_t'(mode);
      op_pos   <= position;
      op_value <= value;
    end
  end

  // pointers and walk state
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cur <= rd_addr_full;
    end
    if (cmd.prev_ld) begin
      prev <= cur;
    end
    case (cmd.node_sel)
      NS_FREE: node <= free_head;
      NS_HEAD: node <= head;
      NS_LINK: node <= link_q;
      default: node <= node;
    endcase
    case (cmd.k_op)
      K_ZERO:  k <= '0;
      K_ONE:   k <= IW'(1);
      K_INC:   k <= k + IW'(1);
      default: k <= k;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      free_head <= '0;
      count     <= '0;
    end else begin
      case (cmd.head_sel)
        HS_NODE: head <= node;
        HS_LINK: head <= link_q;
        default: head <= head;
      endcase
      case (cmd.free_sel)
        FS_LINK: free_head <= link_q;
        FS_NODE: free_head <= node;
        default: free_head <= free_head;
      endcase
      case (cmd.cnt_op)
        CNT_INC: count <= count + IW'(1);
        CNT_DEC: count <= count - IW'(1);
        default: count <= count;
      endcase
    end
  end

  // target position of the operation
  assign count_ext = POS_W'(count);
  assign k_ext     = POS_W'(k);
  assign k_plus    = {1'b0, k} + (IW+1)'(1);

  always_comb begin
    case (op_mode)
      MODE_INS_BACK: target = count_ext;
      MODE_INS_POS:  target = op_pos;
      MODE_DEL_BACK: target = count_ext - POS_W'(1);
      MODE_DEL_POS:  target = op_pos;
      default:       target = '0;
    endcase
  end

  always_comb begin
    case (op_mode)
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS:
        err_code = (count >= NIL) ? ST_FULL : ST_NOTFOUND;
      MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_POS:
        err_code = (count == '0) ? ST_EMPTY : ST_NOTFOUND;
      MODE_LIST: err_code = ST_EMPTY;
      default:   err_code = ST_NOTFOUND;
    endcase
  end

  assign stat.mode       = op_mode;
  assign stat.full       = (count >= NIL);
  assign stat.empty      = (count == '0);
  assign stat.pos_zero   = (target == '0);
  assign stat.pos_gt_cnt = (target > count_ext);
  assign stat.pos_ge_cnt = (target >= count_ext);
  assign stat.k_eq_pos   = (k_ext == target);
  assign stat.list_last  = (k_plus == {1'b0, count});
  assign stat.out_free   = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      last <= cmd.out_last;
      case (cmd.out_sel)
        OUT_OK_ZERO: begin
          status <= ST_OK;
          data   <= '0;
        end
        OUT_OK_VALUE: begin
          status <= ST_OK;
          data   <= val_q;
        end
        default: begin
          status <= err_code;
          data   <= '0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/plle_ctrl.sv -----
// ---------------------------------------------------------------------------
// plle_ctrl
// Controller: sequences each operation over the datapath, one link read per
// cycle while walking, and hands results to the result register.
// ---------------------------------------------------------------------------
module plle_ctrl import plle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  plle_stat_t stat,
  output plle_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE       = 12'b0000_0000_0001,
    S_DECIDE     = 12'b0000_0000_0010,
    S_INS_ALLOC  = 12'b0000_0000_0100,
    S_INS_WALK   = 12'b0000_0000_1000,
    S_INS_LINK   = 12'b0000_0001_0000,
    S_DEL_WALK   = 12'b0000_0010_0000,
    S_DEL_UNLINK = 12'b0000_0100_0000,
    S_DEL_FREE   = 12'b0000_1000_0000,
    S_LIST       = 12'b0001_0000_0000,
    S_RESP_ERR   = 12'b0010_0000_0000,
    S_RESP_OK    = 12'b0100_0000_0000,
    S_RESP_VAL   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_ins;
  logic   is_del;
  logic   is_list;

  assign is_ins  = (stat.mode == MODE_INS_FRONT) || (stat.mode == MODE_INS_BACK) ||
                   (stat.mode == MODE_INS_POS);
  assign is_del  = (stat.mode == MODE_DEL_FRONT) || (stat.mode == MODE_DEL_BACK) ||
                   (stat.mode == MODE_DEL_POS);
  assign is_list = (stat.mode == MODE_LIST);

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op_ld  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (is_list) begin
          if (stat.empty) begin
            state_next = S_RESP_ERR;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_HEAD;
            cmd.k_op   = K_ZERO;
            state_next = S_LIST;
          end
        end else if (is_ins) begin
          if (stat.full || stat.pos_gt_cnt) begin
            state_next = S_RESP_ERR;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RA_FREE;
            cmd.node_sel  = NS_FREE;
            cmd.val_wr_en = 1'b1;
            state_next    = S_INS_ALLOC;
          end
        end else if (is_del) begin
          if (stat.empty || stat.pos_ge_cnt) begin
            state_next = S_RESP_ERR;
          end else if (stat.pos_zero) begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RA_HEAD;
            cmd.node_sel = NS_HEAD;
            state_next   = S_DEL_UNLINK;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_HEAD;
            cmd.k_op   = K_ONE;
            state_next = S_DEL_WALK;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_INS_ALLOC: begin
        cmd.free_sel = FS_LINK;
        if (stat.pos_zero) begin
          cmd.link_wr_en = 1'b1;
          cmd.wa_sel     = WA_NODE;
          cmd.wd_sel     = WD_HEAD;
          cmd.head_sel   = HS_NODE;
          cmd.cnt_op     = CNT_INC;
          state_next     = S_RESP_OK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_HEAD;
          cmd.k_op   = K_ONE;
          state_next = S_INS_WALK;
        end
      end
      S_INS_WALK: begin
        if (stat.k_eq_pos) begin
          cmd.prev_ld    = 1'b1;
          cmd.link_wr_en = 1'b1;
          cmd.wa_sel     = WA_NODE;
          cmd.wd_sel     = WD_LINK;
          state_next     = S_INS_LINK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_LINK;
          cmd.k_op   = K_INC;
        end
      end
      S_INS_LINK: begin
        cmd.link_wr_en = 1'b1;
        cmd.wa_sel     = WA_PREV;
        cmd.wd_sel     = WD_NODE;
        cmd.cnt_op     = CNT_INC;
        state_next     = S_RESP_OK;
      end
      S_DEL_WALK: begin
        if (stat.k_eq_pos) begin
          cmd.prev_ld  = 1'b1;
          cmd.node_sel = NS_LINK;
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RA_LINK;
          state_next   = S_DEL_UNLINK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_LINK;
          cmd.k_op   = K_INC;
        end
      end
      S_DEL_UNLINK: begin
        if (stat.pos_zero) begin
          cmd.head_sel = HS_LINK;
        end else begin
          cmd.link_wr_en = 1'b1;
          cmd.wa_sel     = WA_PREV;
          cmd.wd_sel     = WD_LINK;
        end
        state_next = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.link_wr_en = 1'b1;
        cmd.wa_sel     = WA_NODE;
        cmd.wd_sel     = WD_FREE;
        cmd.free_sel   = FS_NODE;
        cmd.cnt_op     = CNT_DEC;
        state_next     = S_RESP_VAL;
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OUT_OK_VALUE;
          cmd.out_last = stat.list_last;
          if (stat.list_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RA_LINK;
            cmd.k_op   = K_INC;
          end
        end
      end
      S_RESP_ERR: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OUT_ERR;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RESP_OK: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OUT_OK_ZERO;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RESP_VAL: begin
        if (stat.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OUT_OK_VALUE;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/positional_linked_list_engine_core.sv -----
// ---------------------------------------------------------------------------
// positional_linked_list_engine_core
// Bounded singly linked list of signed 32-bit values with a free chain.
// Insert, delete and list operations by front, back or position.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  mode, position, value
//   out      from block out_valid / out_ready status, data, last
//
// an item is taken only while the controller is idle; one item at a time
// insert or delete at the front needs no walk; at p>0 the walk reads
// one link per cycle from the link memory
// list all: one element per cycle from the node memories unless out stalls
// a stalled result waits in the output register while the next item is taken
// reset chains all nodes as free through per-node link valid bits, no sweep
// ---------------------------------------------------------------------------
module positional_linked_list_engine_core import plle_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              mode,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] data,
  output logic                    last
);

  plle_cmd_t  cmd;
  plle_stat_t stat;

  plle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .last      (last)
  );

endmodule

// ----- rtl/plle_checker.sv -----
// ---------------------------------------------------------------------------
// plle_checker
// Port level checks on the linked list engine, bound to the top level.
// ---------------------------------------------------------------------------
module plle_checker import plle_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [2:0]              mode,
  input logic [POS_W-1:0]        position,
  input logic signed [VAL_W-1:0] value,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic signed [VAL_W-1:0] data,
  input logic                    last
);

  // one item in flight: no item taken in the cycle after a take
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken back to back");

  // a waiting item keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(mode) && $stable(position) &&
    $stable(value))
    else $error("waiting item changed");

  // a failing operation gives one result with no data
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> last && (data == '0))
    else $error("error result not single or carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data) &&
    $stable(last))
    else $error("stalled result changed");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind positional_linked_list_engine_core plle_checker u_plle_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the positional linked list engine. Operation items
// are queued up front, a short directed set first and then random grow and
// shrink sequences that walk the list up to full and back down to empty. A
// clocked driver sends them in random bursts, a clocked monitor takes the
// results under a rotating stall pattern, and every result is compared with
// the output of a behavioural list model run when each item is taken.
// ---------------------------------------------------------------------------
module tb;
  import plle_pkg::*;

  localparam int CAP = 32;

  typedef struct {
    mode_t             mode;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
  } list_op_t;

  typedef struct {
    status_t                  status;
    logic signed [VAL_W-1:0]  data;
    logic                     last;
  } list_result_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [2:0]              mode      = MODE_NOP;
  logic [POS_W-1:0]        position  = '0;
  logic signed [VAL_W-1:0] value     = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] data;
  logic                    last;

  list_op_t     pending_ops[$];
  list_result_t due_results[$];
  int           n_queued = 0;
  int           n_taken  = 0;
  int           errors   = 0;

  // list model state
  logic signed [VAL_W-1:0] m_val [CAP];
  int                      m_link[CAP];
  int                      m_head;
  int                      m_free;
  int                      m_count;

  positional_linked_list_engine_core #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .position (position),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .data     (data),
    .last     (last)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void reset_model();
    int i;
    for (i = 0; i < CAP; i++) begin
      m_val[i]  = '0;
      m_link[i] = i + 1;
    end
    m_head  = CAP;
    m_free  = 0;
    m_count = 0;
  endfunction

  function automatic void push_result(status_t s, logic signed [VAL_W-1:0] d, logic l);
    list_result_t r;
    r.status = s;
    r.data   = d;
    r.last   = l;
    due_results.push_back(r);
  endfunction

  function automatic int node_at(int p);
    int cur;
    int i;
    cur = m_head;
    for (i = 0; i < p; i++)
      cur = m_link[cur];
    return cur;
  endfunction

  function automatic void insert_node(int p, logic signed [VAL_W-1:0] v);
    int n;
    int prev;
    if (m_count >= CAP) begin
      push_result(ST_FULL, '0, 1'b1);
    end else if (p > m_count) begin
      push_result(ST_NOTFOUND, '0, 1'b1);
    end else begin
      n        = m_free;
      m_free   = m_link[n];
      m_val[n] = v;
      if (p == 0) begin
        m_link[n] = m_head;
        m_head    = n;
      end else begin
        prev         = node_at(p - 1);
        m_link[n]    = m_link[prev];
        m_link[prev] = n;
      end
      m_count++;
      push_result(ST_OK, '0, 1'b1);
    end
  endfunction

  function automatic void remove_node(int p);
    int n;
    int prev;
    if (m_count == 0) begin
      push_result(ST_EMPTY, '0, 1'b1);
    end else if (p >= m_count) begin
      push_result(ST_NOTFOUND, '0, 1'b1);
    end else begin
      if (p == 0) begin
        n      = m_head;
        m_head = m_link[n];
      end else begin
        prev         = node_at(p - 1);
        n            = m_link[prev];
        m_link[prev] = m_link[n];
      end
      push_result(ST_OK, m_val[n], 1'b1);
      m_link[n] = m_free;
      m_free    = n;
      m_count--;
    end
  endfunction

  function automatic void apply_list_op(list_op_t op);
    int cur;
    int k;
    case (op.mode)
      MODE_INS_FRONT: insert_node(0, op.val);
      MODE_INS_BACK:  insert_node(m_count, op.val);
      MODE_INS_POS:   insert_node(int'(op.pos), op.val);
      MODE_DEL_FRONT: remove_node(0);
      MODE_DEL_BACK:  remove_node(m_count == 0 ? 0 : m_count - 1);
      MODE_DEL_POS:   remove_node(int'(op.pos));
      MODE_LIST: begin
        if (m_count == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          cur = m_head;
          for (k = 0; k < m_count; k++) begin
            push_result(ST_OK, m_val[cur], (k + 1 == m_count));
            cur = m_link[cur];
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_op(mode_t m, int p, logic [VAL_W-1:0] v);
    list_op_t op;
    op.mode = m;
    op.pos  = p[POS_W-1:0];
    op.val  = v;
    pending_ops.push_back(op);
    n_queued++;
  endfunction

  // driver
  list_op_t cur_op;
  int       burst_left = 1;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_op(cur_op);
        n_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          mode     <= cur_op.mode;
          position <= cur_op.pos;
          value    <= cur_op.val;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  logic [7:0]   stall_pat = 8'hff;
  int           pat_age   = 0;
  list_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report($sformatf("unexpected result status %0d data %0d last %0d",
                           status, data, last));
        end else begin
          want = due_results.pop_front();
          if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
          if (data !== want.data)
            report($sformatf("data %0d, expected %0d", data, want.data));
          if (last !== want.last)
            report($sformatf("last %0d, expected %0d", last, want.last));
        end
      end
      pat_age++;
      if (pat_age >= 48) begin
        pat_age = 0;
        case ($urandom_range(0, 3))
          0:       stall_pat = 8'hff;
          1:       stall_pat = 8'($urandom);
          2:       stall_pat = 8'($urandom) | 8'($urandom);
          default: stall_pat = 8'($urandom) & 8'($urandom);
        endcase
        if (stall_pat == 8'h00)
          stall_pat = 8'h01;
      end
      stall_pat = {stall_pat[6:0], stall_pat[7]};
      out_ready <= stall_pat[0];
    end
  end

  // stimulus
  initial begin
    int    sc;
    int    p;
    int    r;
    int    n_rand;
    int    full_tries;
    bit    growing;
    mode_t m;

    reset_model();

    push_op(MODE_LIST,      $urandom_range(0, 255), $urandom);
    push_op(MODE_DEL_FRONT, $urandom_range(0, 255), $urandom);
    push_op(MODE_DEL_BACK,  $urandom_range(0, 255), $urandom);
    push_op(MODE_DEL_POS,   0,   $urandom);
    push_op(MODE_INS_POS,   1,   $urandom);
    push_op(MODE_INS_POS,   255, $urandom);
    push_op(MODE_INS_POS,   0,   32'h7fffffff);
    push_op(MODE_INS_FRONT, 0,   32'h80000000);
    push_op(MODE_INS_BACK,  255, 32'h00000000);
    push_op(MODE_INS_BACK,  0,   32'hffffffff);
    push_op(MODE_INS_POS,   2,   $urandom);
    push_op(MODE_INS_POS,   5,   $urandom);
    push_op(MODE_INS_POS,   7,   $urandom);
    push_op(MODE_LIST,      0,   $urandom);
    push_op(MODE_DEL_POS,   6,   $urandom);
    push_op(MODE_DEL_POS,   255, $urandom);
    push_op(MODE_DEL_POS,   5,   $urandom);
    push_op(MODE_DEL_POS,   2,   $urandom);
    push_op(MODE_DEL_BACK,  0,   $urandom);
    push_op(MODE_DEL_FRONT, 0,   $urandom);
    push_op(MODE_NOP,       255, 32'hffffffff);
    push_op(MODE_LIST,      255, $urandom);
    push_op(MODE_DEL_POS,   0,   $urandom);
    push_op(MODE_DEL_BACK,  0,   $urandom);
    push_op(MODE_LIST,      0,   $urandom);

    // grow to full, bounce off it, then drain to empty, and again
    sc         = 0;
    n_rand     = 0;
    full_tries = 0;
    growing    = 1'b1;
    while (n_rand < 130) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_op(MODE_NOP, $urandom_range(0, 255), $urandom);
      end else begin
        n_rand++;
        if (r < 10) begin
          push_op(MODE_LIST, $urandom_range(0, 255), $urandom);
        end else if (growing ? (r < 75) : (r < 30)) begin
          m = mode_t'($urandom_range(0, 2));
          p = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, sc);
          if (sc >= CAP)
            full_tries++;
          else if (m != MODE_INS_POS || p <= sc)
            sc++;
          push_op(m, (m == MODE_INS_POS) ? p : $urandom_range(0, 255), $urandom);
        end else begin
          m = mode_t'($urandom_range(3, 5));
          p = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, (sc > 0) ? sc - 1 : 0);
          if (sc > 0 && (m != MODE_DEL_POS || p < sc))
            sc--;
          push_op(m, (m == MODE_DEL_POS) ? p : $urandom_range(0, 255), $urandom);
        end
        if (growing && full_tries >= 3)
          growing = 1'b0;
        if (!growing && sc == 0) begin
          growing    = 1'b1;
          full_tries = 0;
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_queued)
      @(posedge clk);
    while (due_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/plle_pkg.sv
rtl/plle_dp.sv
rtl/plle_ctrl.sv
rtl/positional_linked_list_engine_core.sv
rtl/plle_checker.sv
verif/tb.sv
